// ===== hdl/number_to_seven_segment_writer_core_defines.svh =====
// assertion macros used by the digit writer controller
// no dependencies; the including module must have clk and arst_n in scope
`ifndef NUMBER_TO_SEVEN_SEGMENT_WRITER_CORE_DEFINES_SVH
`define NUMBER_TO_SEVEN_SEGMENT_WRITER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define N7SEG_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("n7seg same-cycle check failed");

// next-cycle implication, checked outside reset
`define N7SEG_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("n7seg next-cycle check failed");

`endif

// ===== hdl/n7seg_pkg.sv =====
// types, command codes and segment font for the seven-segment digit writer
// no dependencies
`default_nettype none

package n7seg_pkg;

	// command codes of an input word
	localparam logic [1:0] CMD_DEC   = 2'd0;
	localparam logic [1:0] CMD_HEX   = 2'd1;
	localparam logic [1:0] CMD_POINT = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	// special segment patterns
	localparam logic [7:0] SEG_MINUS = 8'h01;
	localparam logic [7:0] SEG_POINT = 8'h80;

	// digit index width: up to twenty digits plus the minus sign
	localparam int IDX_W = 5;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [7:0]         chip_address;
		logic signed [63:0] value;
		logic [2:0]         start_digit;
		logic [3:0]         min_digits;
		logic [4:0]         point_digit;
	} in_t;

	typedef struct packed {
		logic [7:0] chip_address_res;
		logic [7:0] digit_register;
		logic [7:0] segment_byte;
		logic       last;
	} out_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic conv;
		logic emit_dig;
		logic emit_minus;
		logic emit_clr;
		logic last;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic conv_done;
		logic dig_more;
		logic dig_more_next;
		logic neg;
		logic clr_last;
	} dp_sts_t;

	// hex font, segments a..g in bits 6..0
	function automatic logic [7:0] seg_font(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'h0: s = 8'h7E;
			4'h1: s = 8'h30;
			4'h2: s = 8'h6D;
			4'h3: s = 8'h79;
			4'h4: s = 8'h33;
			4'h5: s = 8'h5B;
			4'h6: s = 8'h5F;
			4'h7: s = 8'h70;
			4'h8: s = 8'h7F;
			4'h9: s = 8'h7B;
			4'hA: s = 8'h77;
			4'hB: s = 8'h1F;
			4'hC: s = 8'h4E;
			4'hD: s = 8'h3D;
			4'hE: s = 8'h4F;
			4'hF: s = 8'h47;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/n7seg_ctrl.sv =====
// controller state machine of the digit writer
// depends on n7seg_pkg and the assertion macro header
`default_nettype none
`include "number_to_seven_segment_writer_core_defines.svh"

module n7seg_ctrl import n7seg_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [1:0] cmd_in,
	input  wire dp_sts_t    sts,
	output dp_cmd_t         dcmd,
	output logic            busy
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CONV  = 3'd1;
	localparam logic [2:0] S_EMIT  = 3'd2;
	localparam logic [2:0] S_MINUS = 3'd3;
	localparam logic [2:0] S_CLR   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign busy = (state_q != S_IDLE);

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		dcmd    = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					dcmd.load = 1'b1;
					case (cmd_in)
						CMD_CLEAR: state_d = S_CLR;
						CMD_HEX:   state_d = S_EMIT;
						default:   state_d = S_CONV;
					endcase
				end
			end
			S_CONV: begin
				dcmd.conv = 1'b1;
				if (sts.conv_done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (sts.dig_more) begin
					dcmd.emit_dig = 1'b1;
					dcmd.last     = !sts.dig_more_next && !sts.neg;
					if (!sts.dig_more_next) begin
						state_d = sts.neg ? S_MINUS : S_IDLE;
					end
				end else begin
					state_d = sts.neg ? S_MINUS : S_IDLE;
				end
			end
			S_MINUS: begin
				dcmd.emit_minus = 1'b1;
				dcmd.last       = 1'b1;
				state_d         = S_IDLE;
			end
			S_CLR: begin
				dcmd.emit_clr = 1'b1;
				dcmd.last     = sts.clr_last;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// checks
	`N7SEG_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0({dcmd.load, dcmd.conv, dcmd.emit_dig, dcmd.emit_minus, dcmd.emit_clr}))
	`N7SEG_ASSERT_IMP(a_emit_busy, dcmd.emit_dig || dcmd.emit_minus || dcmd.emit_clr, busy)
	`N7SEG_ASSERT_NXT(a_load_busy, dcmd.load, busy)
	`N7SEG_ASSERT_NXT(a_last_idle, dcmd.last, !busy)

endmodule

`default_nettype wire

// ===== hdl/n7seg_dp.sv =====
// datapath of the digit writer: operand registers, binary to bcd converter,
// digit shift register and the registered result word; depends on n7seg_pkg
`default_nettype none

module n7seg_dp import n7seg_pkg::*; #(
	parameter int VALUE_WIDTH = 64,
	parameter int DIGIT_BASE  = 1
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire in_t     item,
	input  wire dp_cmd_t dcmd,
	output dp_sts_t      sts,
	output out_t         result,
	output logic         result_valid
);

	localparam int PAD_W = ((VALUE_WIDTH + 3) / 4) * 4;
	localparam int NSTEP = PAD_W / 4;
	localparam int NDEC  = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int ND    = (NDEC > NSTEP) ? NDEC : NSTEP;
	localparam int BCD_W = ND * 4;
	localparam int CNT_W = $clog2(NSTEP);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NSTEP - 1);
	localparam logic [7:0] BASE = 8'(DIGIT_BASE);

	logic [1:0]             mode_q;
	logic [7:0]             chip_q;
	logic [2:0]             start_q;
	logic [3:0]             mind_q;
	logic [4:0]             pdig_q;
	logic                   neg_q;
	logic [PAD_W-1:0]       bin_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [IDX_W-1:0]       idx_q;
	out_t                   result_q;
	logic                   result_valid_q;

	logic [VALUE_WIDTH-1:0] raw;
	logic                   sign;
	logic [VALUE_WIDTH-1:0] mag;
	logic [BCD_W-1:0]       bcd_nx;
	logic [PAD_W-1:0]       bin_nx;
	logic [IDX_W-1:0]       idx_inc;
	logic [7:0]             pos;
	logic [7:0]             seg;

	// magnitude of the incoming value
	assign raw  = item.value[VALUE_WIDTH-1:0];
	assign sign = raw[VALUE_WIDTH-1];
	assign mag  = sign ? (~raw + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : raw;

	// double dabble, four bits per cycle
	always_comb begin
		logic [BCD_W-1:0] b;
		logic [PAD_W-1:0] s;
		b = bcd_q;
		s = bin_q;
		for (int k = 0; k < 4; k++) begin
			for (int j = 0; j < ND; j++) begin
				if (b[j*4 +: 4] >= 4'd5) begin
					b[j*4 +: 4] = b[j*4 +: 4] + 4'd3;
				end
			end
			b = {b[BCD_W-2:0], s[PAD_W-1]};
			s = {s[PAD_W-2:0], 1'b0};
		end
		bcd_nx = b;
		bin_nx = s;
	end

	// status to the controller
	assign idx_inc           = idx_q + 1'b1;
	assign sts.conv_done     = (cnt_q == LAST_STEP);
	assign sts.dig_more      = (bcd_q != '0) || (idx_q < {1'b0, mind_q});
	assign sts.dig_more_next = (bcd_q[BCD_W-1:4] != '0) || (idx_inc < {1'b0, mind_q});
	assign sts.neg           = neg_q;
	assign sts.clr_last      = (idx_q[2:0] == 3'd7);

	// digit position and segment pattern of the current word
	assign pos = BASE + {5'b0, start_q} + {3'b0, idx_q};
	always_comb begin
		seg = seg_font(bcd_q[3:0]);
		if (mode_q == CMD_POINT && idx_q == pdig_q) begin
			seg = seg | SEG_POINT;
		end
	end

	// operand and digit registers
	always_ff @(posedge clk) begin
		if (dcmd.load) begin
			mode_q  <= item.cmd;
			chip_q  <= item.chip_address;
			start_q <= item.start_digit;
			mind_q  <= (item.cmd == CMD_POINT) ? 4'd0 : item.min_digits;
			pdig_q  <= item.point_digit;
			neg_q   <= sign && (item.cmd != CMD_HEX) && (item.cmd != CMD_CLEAR);
			bin_q   <= PAD_W'(mag);
			bcd_q   <= (item.cmd == CMD_HEX) ? BCD_W'(raw) : '0;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else if (dcmd.conv) begin
			bin_q <= bin_nx;
			bcd_q <= bcd_nx;
			cnt_q <= cnt_q + 1'b1;
		end else if (dcmd.emit_dig) begin
			bcd_q <= bcd_q >> 4;
			idx_q <= idx_inc;
		end else if (dcmd.emit_clr) begin
			idx_q <= idx_inc;
		end
	end

	// result word register
	always_ff @(posedge clk) begin
		if (dcmd.emit_dig || dcmd.emit_minus || dcmd.emit_clr) begin
			result_q.chip_address_res <= chip_q;
			result_q.last             <= dcmd.last;
			if (dcmd.emit_clr) begin
				result_q.digit_register <= BASE + {5'b0, ~idx_q[2:0]};
				result_q.segment_byte   <= 8'h00;
			end else if (dcmd.emit_minus) begin
				result_q.digit_register <= pos;
				result_q.segment_byte   <= SEG_MINUS;
			end else begin
				result_q.digit_register <= pos;
				result_q.segment_byte   <= seg;
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= dcmd.emit_dig || dcmd.emit_minus || dcmd.emit_clr;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

`default_nettype wire

// ===== hdl/number_to_seven_segment_writer_core.sv =====
// top level of the seven-segment digit writer: controller plus datapath
// depends on n7seg_pkg, n7seg_ctrl and n7seg_dp
`default_nettype none

// Usage
// An input word (command, chip, value, start digit, minimum digits, point
// digit) is taken at a rising edge with start high and busy low. The block
// answers with a run of digit-register writes, one result word per cycle at
// most, each shown for exactly one cycle with result_valid high; last marks
// the final word of a run. A run that writes nothing (zero value, no padding)
// produces no words at all.
// Sequence of a run:
//   decimal and point: a load step, the converter steps (binary to bcd,
//   four bits a cycle), then one word per digit and one for a minus sign;
//   at most nineteen digits and a minus for 64 bits.
//   hex: a load step, then one word per digit.
//   clear: a load step, then eight words.
// The first word shows in the cycle after the digit phase begins; busy falls
// as the last word is registered, so the next word can be taken while it shows.
// Reset clears the controller and the strobe.
// The receiver cannot stall: each word must be taken in its cycle.
module number_to_seven_segment_writer_core import n7seg_pkg::*; #(
	parameter int VALUE_WIDTH = 64,
	parameter int DIGIT_BASE  = 1
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire in_t  item,
	output out_t      result,
	output logic      result_valid
);

	dp_cmd_t dcmd;
	dp_sts_t sts;

	// sequencer
	n7seg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd_in (item.cmd),
		.sts    (sts),
		.dcmd   (dcmd),
		.busy   (busy)
	);

	// converter and output word
	n7seg_dp #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.DIGIT_BASE  (DIGIT_BASE)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.dcmd         (dcmd),
		.sts          (sts),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// self-checking testbench for number_to_seven_segment_writer_core
// depends on n7seg_pkg and the core rtl; drives command words, predicts digit writes
`timescale 1ns / 1ps

module tb;
	import n7seg_pkg::*;

	localparam int VALUE_WIDTH = 64;
	localparam int DIGIT_BASE  = 1;

	// segment glyphs 0..f, digit 0 in the low byte
	localparam logic [127:0] GLYPHS = {
		8'h47, 8'h4F, 8'h3D, 8'h4E, 8'h1F, 8'h77, 8'h7B, 8'h7F,
		8'h70, 8'h5F, 8'h5B, 8'h33, 8'h79, 8'h6D, 8'h30, 8'h7E
	};

	// one directed row: typed_n < 0 means the predictor supplies the writes
	typedef struct {
		in_t        w;
		int         typed_n;
		logic [7:0] typed_seg;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	in_t  item;
	out_t result;
	logic result_valid;

	out_t      pending_writes[$];
	stim_row_t plan[$];
	int        idle_pct;
	int        n_mismatch;
	int        n_checked;
	int        n_by_cmd[4];

	number_to_seven_segment_writer_core #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.DIGIT_BASE (DIGIT_BASE)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.item        (item),
		.result      (result),
		.result_valid(result_valid)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop
	initial begin
		#5_000_000;
		$display("timeout with %0d writes outstanding", pending_writes.size());
		$display("[number_to_seven_segment_writer_core] ERROR");
		$finish;
	end

	function automatic out_t make_write(input logic [7:0] chip, input int pos,
		input logic [7:0] seg);
		out_t o;
		o.chip_address_res = chip;
		o.digit_register   = 8'(DIGIT_BASE + pos);
		o.segment_byte     = seg;
		o.last             = 1'b0;
		return o;
	endfunction

	// mark the final write of a run and queue the run
	function automatic void append_run(input out_t run[$]);
		foreach (run[k]) begin
			run[k].last = (k == run.size() - 1);
			pending_writes.push_back(run[k]);
		end
	endfunction

	// expected digit writes for one command word
	function automatic void queue_digit_writes(input in_t w);
		out_t        run[$];
		logic [63:0] raw;
		logic [63:0] mag;
		logic [63:0] rem;
		logic        neg;
		logic [7:0]  seg;
		int          n;
		raw = w.value;
		n = 0;
		neg = 1'b0;
		if (w.cmd == CMD_CLEAR) begin
			for (int p = 7; p >= 0; p--)
				run.push_back(make_write(w.chip_address, p, 8'h00));
		end else if (w.cmd == CMD_HEX) begin
			mag = raw;
			while (mag != 0 || n < w.min_digits) begin
				run.push_back(make_write(w.chip_address, w.start_digit + n,
					GLYPHS[{mag[3:0], 3'b000} +: 8]));
				mag = mag >> 4;
				n++;
			end
		end else begin
			// magnitude as unsigned, so the most negative value shows in full
			neg = raw[63];
			mag = neg ? (~raw + 64'd1) : raw;
			while (mag != 0 || (w.cmd == CMD_DEC && n < w.min_digits)) begin
				rem = mag % 64'd10;
				seg = GLYPHS[{rem[3:0], 3'b000} +: 8];
				if (w.cmd == CMD_POINT && n == w.point_digit)
					seg = seg | SEG_POINT;
				run.push_back(make_write(w.chip_address, w.start_digit + n, seg));
				mag = mag / 64'd10;
				n++;
			end
			if (neg)
				run.push_back(make_write(w.chip_address, w.start_digit + n, SEG_MINUS));
		end
		append_run(run);
	endfunction

	// present one word, wait for it to be taken, then record the expectation
	task automatic send_word(input in_t w, input int typed_n, input logic [7:0] typed_seg);
		out_t run[$];
		int   pos;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item  <= w;
		do
			@(posedge clk);
		while (busy);
		n_by_cmd[w.cmd]++;
		if (typed_n >= 0) begin
			for (int i = 0; i < typed_n; i++) begin
				pos = (w.cmd == CMD_CLEAR) ? 7 - i : w.start_digit + i;
				run.push_back(make_write(w.chip_address, pos, typed_seg));
			end
			append_run(run);
		end else begin
			queue_digit_writes(w);
		end
	endtask

	function automatic stim_row_t mk_row(input logic [1:0] cmd, input logic [7:0] chip,
		input logic [63:0] val, input logic [2:0] sd, input logic [3:0] md,
		input logic [4:0] pd, input int tn, input logic [7:0] ts);
		stim_row_t r;
		r.w.cmd          = cmd;
		r.w.chip_address = chip;
		r.w.value        = val;
		r.w.start_digit  = sd;
		r.w.min_digits   = md;
		r.w.point_digit  = pd;
		r.typed_n        = tn;
		r.typed_seg      = ts;
		return r;
	endfunction

	// random word, biased toward values that give long and signed runs
	function automatic in_t random_word();
		in_t         w;
		logic [63:0] v;
		int          r;
		r = $urandom_range(15);
		w.cmd = (r < 5) ? CMD_DEC : (r < 9) ? CMD_HEX : (r < 14) ? CMD_POINT : CMD_CLEAR;
		w.chip_address = 8'($urandom_range(255));
		w.start_digit  = 3'($urandom_range(7));
		w.min_digits   = ($urandom_range(7) == 0) ? 4'($urandom_range(15, 9))
			: 4'($urandom_range(8));
		w.point_digit  = ($urandom_range(7) == 0) ? 5'($urandom_range(31, 20))
			: 5'($urandom_range(19));
		case ($urandom_range(9))
			0: v = 64'd0;
			1, 2: v = 64'($urandom_range(9999));
			3: v = -64'($urandom_range(9999, 1));
			4, 5, 6: v = {$urandom, $urandom};
			7: begin
				case ($urandom_range(3))
					0: v = 64'h7FFF_FFFF_FFFF_FFFF;
					1: v = 64'h8000_0000_0000_0000;
					2: v = '1;
					default: v = 64'd1;
				endcase
			end
			8: begin
				v = {$urandom, $urandom} >> $urandom_range(63);
				if ($urandom_range(1))
					v = -v;
			end
			default: begin
				// around a power of ten
				v = 64'd1;
				repeat ($urandom_range(18))
					v = v * 64'd10;
				v = v - 64'($urandom_range(1));
				if ($urandom_range(1))
					v = -v;
			end
		endcase
		w.value = v;
		return w;
	endfunction

	task automatic report_mismatch(input string what, input out_t got, input out_t want);
		n_mismatch++;
		if (n_mismatch <= 10)
			$display("%t mismatch (%s): got chip %02h reg %02h seg %02h last %0b,",
				$realtime, what, got.chip_address_res, got.digit_register,
				got.segment_byte, got.last, " want chip %02h reg %02h seg %02h last %0b",
				want.chip_address_res, want.digit_register, want.segment_byte, want.last);
	endtask

	// result checker: every strobed word against the oldest expectation
	always @(posedge clk) begin
		out_t want;
		if (arst_n && result_valid) begin
			if (pending_writes.size() == 0) begin
				want = '0;
				report_mismatch("unexpected word", result, want);
			end else begin
				want = pending_writes.pop_front();
				n_checked++;
				if (result.chip_address_res !== want.chip_address_res
					|| result.digit_register !== want.digit_register
					|| result.segment_byte !== want.segment_byte
					|| result.last !== want.last)
					report_mismatch("field", result, want);
			end
		end
	end

	// stimulus
	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		item       = '0;
		idle_pct   = 10;
		n_mismatch = 0;
		n_checked  = 0;
		foreach (n_by_cmd[c])
			n_by_cmd[c] = 0;

		//                cmd        chip   value                    sd mind pd typed seg
		plan.push_back(mk_row(CMD_DEC,   8'h00, 64'd0,                   0, 0, 0, 0, 8'h00));
		plan.push_back(mk_row(CMD_HEX,   8'hFF, 64'd0,                   7, 0, 0, 0, 8'h00));
		plan.push_back(mk_row(CMD_POINT, 8'h12, 64'd0,                   3, 8, 0, 0, 8'h00));
		plan.push_back(mk_row(CMD_CLEAR, 8'hFF, 64'd0,                   5, 0, 0, 8, 8'h00));
		plan.push_back(mk_row(CMD_DEC,   8'h01, 64'd0,                   0, 8, 0, 8, 8'h7E));
		plan.push_back(mk_row(CMD_HEX,   8'hA5, 64'hFFFF_FFFF_FFFF_FFFF, 7, 0, 0, 16, 8'h47));
		plan.push_back(mk_row(CMD_DEC,   8'h5A, 64'h7FFF_FFFF_FFFF_FFFF, 7, 0, 0, -1, 8'h00));
		plan.push_back(mk_row(CMD_DEC,   8'h80, 64'h8000_0000_0000_0000, 0, 0, 0, -1, 8'h00));
		plan.push_back(mk_row(CMD_DEC,   8'h33, 64'hFFFF_FFFF_FFFF_FFFF, 2, 8, 0, -1, 8'h00));
		plan.push_back(mk_row(CMD_HEX,   8'h44, 64'h8000_0000_0000_0000, 0, 0, 0, -1, 8'h00));
		plan.push_back(mk_row(CMD_HEX,   8'h55, 64'h0123_4567_89AB_CDEF, 1, 8, 0, -1, 8'h00));
		plan.push_back(mk_row(CMD_HEX,   8'h66, 64'd0,                   4, 8, 0, -1, 8'h00));
		plan.push_back(mk_row(CMD_POINT, 8'h77, 64'd12345,               0, 0, 0, -1, 8'h00));
		plan.push_back(mk_row(CMD_POINT, 8'h88, -64'd12345,              6, 3, 4, -1, 8'h00));
		plan.push_back(mk_row(CMD_POINT, 8'h99, 64'd123,                 1, 0, 3, -1, 8'h00));
		plan.push_back(mk_row(CMD_POINT, 8'hAA, 64'h8000_0000_0000_0000, 0, 0, 19, -1, 8'h00));
		plan.push_back(mk_row(CMD_POINT, 8'hBB, 64'h7FFF_FFFF_FFFF_FFFF, 7, 0, 18, -1, 8'h00));
		plan.push_back(mk_row(CMD_DEC,   8'hCC, 64'd5,                   6, 3, 0, -1, 8'h00));
		plan.push_back(mk_row(CMD_DEC,   8'hDD, -64'd7,                  3, 0, 0, -1, 8'h00));
		plan.push_back(mk_row(CMD_DEC,   8'hEE, 64'd1234567890,          0, 15, 31, -1, 8'h00));
		plan.push_back(mk_row(CMD_HEX,   8'h0F, 64'd1,                   5, 15, 0, -1, 8'h00));
		plan.push_back(mk_row(CMD_CLEAR, 8'h3C, 64'h5555_AAAA_5555_AAAA, 0, 15, 31, 8, 8'h00));
		plan.push_back(mk_row(CMD_POINT, 8'hC3, 64'd1,                   2, 0, 31, -1, 8'h00));
		plan.push_back(mk_row(CMD_POINT, 8'h81, -64'd1,                  4, 0, 0, -1, 8'h00));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send_word(plan[i].w, plan[i].typed_n, plan[i].typed_seg);

		// random words: light sender gaps, heavy gaps, then back to back
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 10 : (ph == 1) ? 71 : 0;
			repeat (160)
				send_word(random_word(), -1, 8'h00);
		end
		start <= 1'b0;

		// drain, then allow for a run still in flight that writes nothing
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (48) @(posedge clk);

		if (pending_writes.size() != 0)
			n_mismatch++;
		$display("covered %0d decimal, %0d hex, %0d point and %0d clear words;",
			n_by_cmd[CMD_DEC], n_by_cmd[CMD_HEX], n_by_cmd[CMD_POINT], n_by_cmd[CMD_CLEAR],
			" %0d digit writes checked, %0d mismatches", n_checked, n_mismatch);
		if (n_mismatch == 0)
			$display("[number_to_seven_segment_writer_core] OK");
		else
			$display("[number_to_seven_segment_writer_core] ERROR");
		$finish;
	end

endmodule

// ===== number_to_seven_segment_writer_core.f =====
+incdir+hdl
hdl/n7seg_pkg.sv
hdl/n7seg_ctrl.sv
hdl/n7seg_dp.sv
hdl/number_to_seven_segment_writer_core.sv
tb/sv/tb.sv
